FILE: rtl/core/pma_pkg.sv
// Shared types, register codes and coefficient constants for the pointer
// motion accelerator. No dependencies.
`default_nettype none
package pma_pkg;

    typedef enum logic [1:0] {
        MODE_POINTER = 2'd0,
        MODE_SCROLL  = 2'd1,
        MODE_CARET   = 2'd2,
        MODE_VOLUME  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_POINTER_QUAD_X   = 3'd0,
        REG_POINTER_QUAD_Y   = 3'd1,
        REG_SCROLL_QUAD_X    = 3'd2,
        REG_SCROLL_QUAD_Y    = 3'd3,
        REG_CARET_QUAD_X     = 3'd4,
        REG_CARET_QUAD_Y     = 3'd5,
        REG_LINEAR_BASE      = 3'd6,
        REG_SNAP_THRESHOLD   = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [15:0] pointer_quad_x;
        logic [15:0] pointer_quad_y;
        logic [15:0] scroll_quad_x;
        logic [15:0] scroll_quad_y;
        logic [15:0] caret_quad_x;
        logic [15:0] caret_quad_y;
        logic [15:0] linear_base;
        logic [15:0] snap_threshold;
    } coef_t;

    localparam coef_t COEF_RESET = '{
        pointer_quad_x:   16'd1280,
        pointer_quad_y:   16'd1228,
        scroll_quad_x:    16'd1280,
        scroll_quad_y:    16'd1228,
        caret_quad_x:     16'd64,
        caret_quad_y:     16'd64,
        linear_base:      16'd25,
        snap_threshold:   16'd332
    };

    // 8.8 gains: 1.3 for caret x, 1.0 for caret y and volume x, 2.0 for volume y
    localparam logic [15:0] GAIN_CARET_X  = 16'd332;
    localparam logic [15:0] GAIN_UNITY    = 16'd256;
    localparam logic [15:0] GAIN_VOLUME_Y = 16'd512;
    localparam logic [23:0] BASE_SCALE    = 24'd153;

    // per-axis operands handed to a lane
    typedef struct packed {
        logic [14:0] sq;
        logic [7:0]  mag;
        logic        pos;
        logic [15:0] quad;
        logic [15:0] lin;
    } lane_in_t;

    // per-axis partial terms, both already shifted by 8
    typedef struct packed {
        logic [22:0] qterm;
        logic [16:0] lterm;
        logic        pos;
    } lane_out_t;

    // linear gain for pointer and scroll: floor(base * 153 / 256), about base * 0.6
    function automatic logic [15:0] linear_gain(input logic [15:0] base);
        logic signed [23:0] p;
        begin
            p = $signed({{8{base[15]}}, base}) * $signed(BASE_SCALE);
            return p[23:8];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pointer_motion_accelerator.sv
// Pointer motion accelerator top level: config registers, pipeline control,
// snap stage, two axis lanes and merge stage. Depends on pma_pkg.
//
// Usage:
//   Input stream s_*: one motion report per request. s_tuser carries the
//   mode (0 pointer, 1 scroll, 2 caret, 3 volume); s_tdata carries delta_x
//   and delta_y. Output stream m_*: one accelerated report per input, in
//   order, with out_x and out_y saturated to -127..127.
//   Config channel cfg_*: index 0..7 selects a coefficient register, data is
//   16-bit 8.8 fixed point. cfg_ready is always high; write only while idle.
// Timing:
//   Three register stages (snap, lane products, merge). The snap stage
//   squares and threshold-scales each magnitude, each lane holds two
//   multiplies; one report is accepted every cycle while m_tready is high.
// Reset:
//   rst_n low empties the pipeline and loads the default coefficients.
// Stall:
//   With m_tready low the output holds; upstream stages keep filling any
//   empty slot, and s_tready falls only once all stages hold a report.
`default_nettype none
module pointer_motion_accelerator
    import pma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] delta_x, [15:8] delta_y
    input  wire logic [1:0]  s_tuser,   // [1:0] motion_mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_x, [15:8] out_y
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_data
);

    coef_t       coef_reg;
    coef_t       coef_next;
    logic [15:0] gain_reg;
    logic [15:0] gain_next;
    logic        snap_valid_reg;
    logic        lane_valid_reg;
    logic        out_valid_reg;
    logic        en_snap;
    logic        en_lane;
    logic        en_out;
    lane_in_t    lane_in_x;
    lane_in_t    lane_in_y;
    lane_out_t   lane_out_x;
    lane_out_t   lane_out_y;

    assign cfg_ready = 1'b1;
    assign en_out    = !out_valid_reg || m_tready;
    assign en_lane   = !lane_valid_reg || en_out;
    assign en_snap   = !snap_valid_reg || en_lane;
    assign s_tready  = en_snap;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        coef_next = coef_reg;
        gain_next = gain_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_POINTER_QUAD_X:   coef_next.pointer_quad_x = cfg_data;
                REG_POINTER_QUAD_Y:   coef_next.pointer_quad_y = cfg_data;
                REG_SCROLL_QUAD_X:    coef_next.scroll_quad_x = cfg_data;
                REG_SCROLL_QUAD_Y:    coef_next.scroll_quad_y = cfg_data;
                REG_CARET_QUAD_X:     coef_next.caret_quad_x = cfg_data;
                REG_CARET_QUAD_Y:     coef_next.caret_quad_y = cfg_data;
                REG_LINEAR_BASE:
                begin
                    coef_next.linear_base = cfg_data;
                    gain_next = linear_gain(cfg_data);
                end
                REG_SNAP_THRESHOLD:   coef_next.snap_threshold = cfg_data;
                default:              coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg       <= COEF_RESET;
            gain_reg       <= linear_gain(COEF_RESET.linear_base);
            snap_valid_reg <= 1'b0;
            lane_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            coef_reg <= coef_next;
            gain_reg <= gain_next;
            if (en_snap)
                snap_valid_reg <= s_tvalid;
            if (en_lane)
                lane_valid_reg <= snap_valid_reg;
            if (en_out)
                out_valid_reg <= lane_valid_reg;
        end
    end

    pma_snap u_snap (
        .clk        (clk),
        .en         (en_snap),
        .mode       (s_tuser),
        .dx         (s_tdata[7:0]),
        .dy         (s_tdata[15:8]),
        .coef       (coef_reg),
        .gain       (gain_reg),
        .lane_x_reg (lane_in_x),
        .lane_y_reg (lane_in_y)
    );

    pma_lane u_lane_x (
        .clk          (clk),
        .en           (en_lane),
        .lane_in      (lane_in_x),
        .lane_out_reg (lane_out_x)
    );

    pma_lane u_lane_y (
        .clk          (clk),
        .en           (en_lane),
        .lane_in      (lane_in_y),
        .lane_out_reg (lane_out_y)
    );

    pma_merge u_merge (
        .clk       (clk),
        .en        (en_out),
        .lane_x    (lane_out_x),
        .lane_y    (lane_out_y),
        .tdata_reg (m_tdata)
    );

endmodule
`default_nettype wire

FILE: rtl/core/pma_snap.sv
// Input stage: magnitudes, axis snapping per mode and coefficient selection.
// Depends on pma_pkg.
`default_nettype none
module pma_snap
    import pma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  dx,
    input  wire logic [7:0]  dy,
    input  wire coef_t       coef,
    input  wire logic [15:0] gain,
    output lane_in_t         lane_x_reg,
    output lane_in_t         lane_y_reg
);

    logic [7:0]         ax;
    logic [7:0]         ay;
    logic [15:0]        sqx;
    logic [15:0]        sqy;
    logic signed [24:0] thr_y_p;
    logic signed [24:0] thr_x_p;
    logic signed [16:0] thr_y;
    logic signed [16:0] thr_x;
    logic               zero_x;
    logic               zero_y;
    lane_in_t           lane_x_next;
    lane_in_t           lane_y_next;

    always_comb
    begin
        ax = dx[7] ? 8'(-dx) : dx;
        ay = dy[7] ? 8'(-dy) : dy;
        sqx = {8'd0, ax} * {8'd0, ax};
        sqy = {8'd0, ay} * {8'd0, ay};
        thr_y_p = $signed({17'd0, ay}) * $signed({{9{coef.snap_threshold[15]}},
                                                  coef.snap_threshold});
        thr_x_p = $signed({17'd0, ax}) * $signed({{9{coef.snap_threshold[15]}},
                                                  coef.snap_threshold});
        thr_y = thr_y_p[24:8];
        thr_x = thr_x_p[24:8];

        zero_x = 1'b0;
        zero_y = 1'b0;
        lane_x_next.quad = 16'd0;
        lane_y_next.quad = 16'd0;
        lane_x_next.lin  = GAIN_UNITY;
        lane_y_next.lin  = GAIN_VOLUME_Y;
        unique case (mode_t'(mode))
            MODE_POINTER:
            begin
                lane_x_next.quad = coef.pointer_quad_x;
                lane_y_next.quad = coef.pointer_quad_y;
                lane_x_next.lin  = gain;
                lane_y_next.lin  = gain;
            end
            MODE_SCROLL:
            begin
                zero_y = ax > ay;
                zero_x = !(ax > ay);
                lane_x_next.quad = coef.scroll_quad_x;
                lane_y_next.quad = coef.scroll_quad_y;
                lane_x_next.lin  = gain;
                lane_y_next.lin  = gain;
            end
            MODE_CARET:
            begin
                zero_y = thr_y < $signed({9'd0, ax});
                zero_x = !zero_y && (thr_x < $signed({9'd0, ay}));
                lane_x_next.quad = coef.caret_quad_x;
                lane_y_next.quad = coef.caret_quad_y;
                lane_x_next.lin  = GAIN_CARET_X;
                lane_y_next.lin  = GAIN_UNITY;
            end
            MODE_VOLUME:
            begin
                lane_x_next.lin  = GAIN_UNITY;
                lane_y_next.lin  = GAIN_VOLUME_Y;
            end
            default:
            begin
                lane_x_next.lin  = GAIN_UNITY;
            end
        endcase

        lane_x_next.sq  = zero_x ? 15'd0 : sqx[14:0];
        lane_x_next.mag = zero_x ? 8'd0 : ax;
        lane_x_next.pos = !zero_x && !dx[7] && (dx != 8'd0);
        lane_y_next.sq  = zero_y ? 15'd0 : sqy[14:0];
        lane_y_next.mag = zero_y ? 8'd0 : ay;
        lane_y_next.pos = !zero_y && !dy[7] && (dy != 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_x_reg <= lane_x_next;
            lane_y_reg <= lane_y_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pma_lane.sv
// One axis lane: quadratic and linear products, each shifted back to integer.
// Depends on pma_pkg.
`default_nettype none
module pma_lane
    import pma_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire lane_in_t lane_in,
    output lane_out_t     lane_out_reg
);

    logic signed [30:0] quad_p;
    logic signed [24:0] lin_p;
    lane_out_t          lane_out_next;

    always_comb
    begin
        quad_p = $signed({16'd0, lane_in.sq})
               * $signed({{15{lane_in.quad[15]}}, lane_in.quad});
        lin_p  = $signed({17'd0, lane_in.mag})
               * $signed({{9{lane_in.lin[15]}}, lane_in.lin});
        lane_out_next.qterm = quad_p[30:8];
        lane_out_next.lterm = lin_p[24:8];
        lane_out_next.pos   = lane_in.pos;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_out_reg <= lane_out_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pma_merge.sv
// Output stage: sums the lane terms, applies sign, saturates, packs tdata.
// Depends on pma_pkg.
`default_nettype none
module pma_merge
    import pma_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire lane_out_t lane_x,
    input  wire lane_out_t lane_y,
    output logic [15:0]    tdata_reg
);

    logic [15:0] tdata_next;

    function automatic logic [7:0] finish(input lane_out_t t);
        logic signed [23:0] acc;
        logic signed [23:0] res;
        begin
            acc = $signed({t.qterm[22], t.qterm})
                + $signed({{7{t.lterm[16]}}, t.lterm});
            res = t.pos ? acc : -acc;
            if (res > 24'sd127)
                return 8'sd127;
            else if (res < -24'sd127)
                return -8'sd127;
            else
                return res[7:0];
        end
    endfunction

    always_comb
    begin
        tdata_next = {finish(lane_y), finish(lane_x)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdata_reg <= tdata_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/pma_checker.sv
// Port-level checks for the pointer motion accelerator, bound to the top.
// No package dependency.
`default_nettype none
module pma_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output changed");

    // saturation never yields -128 on either axis
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] != 8'h80) && (m_tdata[15:8] != 8'h80))
        else $error("output outside saturation range");

    // empty output slot means the whole pipe can advance
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // reset empties the output
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind pointer_motion_accelerator pma_checker u_pma_checker (.*);
`default_nettype wire
